// File: design/matrix_inverse_3x3_assert.svh
// Assertion macros shared by the matrix inverse modules.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef MATRIX_INVERSE_3X3_ASSERT_SVH
`define MATRIX_INVERSE_3X3_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MI3_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MI3_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/mi3_pkg.sv
// Package for the 3x3 matrix inverse: fixed-point widths, beat types,
// internal bus structs and the minor and cofactor index tables. No dependencies.
package mi3_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int N_ENTRY    = 9;

    localparam int PROD_W  = 2 * DATA_WIDTH;
    localparam int MINOR_W = 2 * DATA_WIDTH + 1;
    localparam int TERM_W  = 3 * DATA_WIDTH + 1;
    localparam int DET_W   = 3 * DATA_WIDTH + 3;
    localparam int QUO_W   = DATA_WIDTH + 1;
    localparam int NUM_W   = MINOR_W + 2 * FRAC_BITS;

    // Divider: one setup stage, one stage per quotient bit, one output stage.
    localparam int DIV_LAT = QUO_W + 2;
    // Accept edge to the edge at which the result beat is taken.
    localparam int LATENCY = DIV_LAT + 7;

    typedef logic signed [DATA_WIDTH-1:0] entry_t;
    typedef logic signed [MINOR_W-1:0]    minor_t;
    typedef logic signed [DET_W-1:0]      det_t;
    typedef logic [MINOR_W-1:0]           minor_mag_t;
    typedef logic [DET_W-1:0]             det_mag_t;
    typedef logic [3:0]                   idx_t;

    typedef entry_t entry_arr_t [N_ENTRY];
    typedef idx_t   minor_ops_t [N_ENTRY][4];
    typedef idx_t   cof_map_t   [N_ENTRY];

    typedef struct packed {
        entry_t m_xx;
        entry_t m_xy;
        entry_t m_xz;
        entry_t m_yx;
        entry_t m_yy;
        entry_t m_yz;
        entry_t m_zx;
        entry_t m_zy;
        entry_t m_zz;
    } matrix_t;

    typedef struct packed {
        entry_t inv_xx;
        entry_t inv_xy;
        entry_t inv_xz;
        entry_t inv_yx;
        entry_t inv_yy;
        entry_t inv_yz;
        entry_t inv_zx;
        entry_t inv_zy;
        entry_t inv_zz;
        logic   singular;
        logic   saturated;
    } inverse_t;

    typedef struct packed {
        logic                     valid;
        entry_t [2:0]             row;
        minor_t [N_ENTRY-1:0]     m;
    } minor_bus_t;

    typedef struct packed {
        logic                     valid;
        det_t                     det;
        minor_t [N_ENTRY-1:0]     m;
    } det_bus_t;

    typedef struct packed {
        logic       valid;
        logic       neg;
        minor_mag_t mag;
        det_mag_t   den;
    } div_in_t;

    typedef struct packed {
        logic   valid;
        entry_t value;
        logic   sat;
    } div_out_t;

    // Entry indices (row-major) of the two products that form each minor.
    localparam minor_ops_t MINOR_OPS = '{
        '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd3, 4'd8, 4'd5, 4'd6}, '{4'd3, 4'd7, 4'd4, 4'd6},
        '{4'd1, 4'd8, 4'd2, 4'd7}, '{4'd0, 4'd8, 4'd6, 4'd2}, '{4'd0, 4'd7, 4'd1, 4'd6},
        '{4'd1, 4'd5, 4'd2, 4'd4}, '{4'd0, 4'd5, 4'd2, 4'd3}, '{4'd0, 4'd4, 4'd1, 4'd3}
    };

    // Minor feeding each output position; odd positions take its negation.
    localparam cof_map_t COF_OF_OUT = '{
        4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8
    };

    function automatic entry_arr_t unpack_matrix(matrix_t mat);
        entry_arr_t a;
        a[0] = mat.m_xx;
        a[1] = mat.m_xy;
        a[2] = mat.m_xz;
        a[3] = mat.m_yx;
        a[4] = mat.m_yy;
        a[5] = mat.m_yz;
        a[6] = mat.m_zx;
        a[7] = mat.m_zy;
        a[8] = mat.m_zz;
        return a;
    endfunction

endpackage

// File: design/mi3_minor.sv
// Two-stage minor unit: eighteen entry products, then the nine 2x2 minors.
// Depends on mi3_pkg.
module mi3_minor
    import mi3_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  matrix_t    mat,
    output minor_bus_t out
);

    entry_arr_t a;
    logic signed [PROD_W-1:0] prod_next [N_ENTRY][2];
    logic signed [PROD_W-1:0] prod_reg  [N_ENTRY][2];
    entry_t [2:0]             row1_reg;
    entry_t [2:0]             row2_reg;
    minor_t [N_ENTRY-1:0]     minor_next;
    minor_t [N_ENTRY-1:0]     minor_reg;
    logic                     v1_reg;
    logic                     v2_reg;

    assign a = unpack_matrix(mat);

    for (genvar i = 0; i < N_ENTRY; i++) begin : g_minor
        assign prod_next[i][0] = a[MINOR_OPS[i][0]] * a[MINOR_OPS[i][1]];
        assign prod_next[i][1] = a[MINOR_OPS[i][2]] * a[MINOR_OPS[i][3]];
        assign minor_next[i]   = MINOR_W'(prod_reg[i][0]) - MINOR_W'(prod_reg[i][1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        row1_reg  <= {a[2], a[1], a[0]};
        row2_reg  <= row1_reg;
        minor_reg <= minor_next;
    end

    always_comb
    begin
        out.valid = v2_reg;
        out.row   = row2_reg;
        out.m     = minor_reg;
    end

endmodule

// File: design/mi3_det.sv
// Three-stage determinant unit: split partial products, row terms, then the sum.
// The nine minors ride along unchanged. Depends on mi3_pkg.
module mi3_det
    import mi3_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  minor_bus_t in,
    output det_bus_t   out
);

    logic signed [MINOR_W-1:0] lo_next  [3];
    logic signed [MINOR_W-1:0] hi_next  [3];
    logic signed [MINOR_W-1:0] lo_reg   [3];
    logic signed [MINOR_W-1:0] hi_reg   [3];
    logic signed [TERM_W-1:0]  term_next[3];
    logic signed [TERM_W-1:0]  term_reg [3];
    det_t                      det_next;
    det_t                      det_reg;
    minor_t [N_ENTRY-1:0]      m3_reg;
    minor_t [N_ENTRY-1:0]      m4_reg;
    minor_t [N_ENTRY-1:0]      m5_reg;
    logic                      v3_reg;
    logic                      v4_reg;
    logic                      v5_reg;

    // Each minor is split into an unsigned low word and a signed high part so
    // that no product is wider than one entry by one entry plus a bit.
    for (genvar k = 0; k < 3; k++) begin : g_term
        assign lo_next[k]   = in.row[k] * $signed({1'b0, in.m[k][DATA_WIDTH-1:0]});
        assign hi_next[k]   = in.row[k] * $signed(in.m[k][MINOR_W-1:DATA_WIDTH]);
        assign term_next[k] = (TERM_W'(hi_reg[k]) <<< DATA_WIDTH) + TERM_W'(lo_reg[k]);
    end

    assign det_next = DET_W'(term_reg[0]) - DET_W'(term_reg[1]) + DET_W'(term_reg[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= in.valid;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        term_reg <= term_next;
        det_reg  <= det_next;
        m3_reg   <= in.m;
        m4_reg   <= m3_reg;
        m5_reg   <= m4_reg;
    end

    always_comb
    begin
        out.valid = v5_reg;
        out.det   = det_reg;
        out.m     = m5_reg;
    end

endmodule

// File: design/mi3_div.sv
// Pipelined restoring divider for one inverse entry: one quotient bit per stage,
// then saturation and sign. Depends on mi3_pkg and the assertion macro header.
`include "matrix_inverse_3x3_assert.svh"

module mi3_div
    import mi3_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_in_t  din,
    output div_out_t dout
);

    localparam int CMP_W = (NUM_W > DET_W + QUO_W) ? NUM_W : DET_W + QUO_W;
    localparam logic [QUO_W-1:0] LIM_POS = {2'b00, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [QUO_W-1:0] LIM_NEG = {2'b01, {(DATA_WIDTH-1){1'b0}}};

    logic [CMP_W-1:0] num_ext;
    logic [CMP_W-1:0] den_ext;

    logic             valid_reg [QUO_W+1];
    logic             ovf_reg   [QUO_W+1];
    logic             neg_reg   [QUO_W+1];
    det_mag_t         rem_reg   [QUO_W+1];
    det_mag_t         den_reg   [QUO_W+1];
    logic [QUO_W-1:0] low_reg   [QUO_W+1];
    logic [QUO_W-1:0] quo_reg   [QUO_W+1];

    logic             clip;
    logic [QUO_W-1:0] lim;
    logic [QUO_W-1:0] mag_sat;
    logic [QUO_W-1:0] signed_q;
    logic             out_valid_reg;
    entry_t           out_value_reg;
    logic             out_sat_reg;

    // The numerator is |minor| scaled by 2^(2F). A quotient of 2^QUO_W or more
    // always saturates, so only the low QUO_W quotient bits are developed.
    assign num_ext = CMP_W'(din.mag) << (2 * FRAC_BITS);
    assign den_ext = CMP_W'(din.den) << QUO_W;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= din.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        ovf_reg[0] <= (num_ext >= den_ext);
        neg_reg[0] <= din.neg;
        rem_reg[0] <= DET_W'(num_ext >> QUO_W);
        den_reg[0] <= din.den;
        low_reg[0] <= num_ext[QUO_W-1:0];
        quo_reg[0] <= '0;
    end

    for (genvar k = 1; k <= QUO_W; k++) begin : g_stage
        logic [DET_W:0]   trial;
        logic [DET_W+1:0] diff;
        logic             ge;

        assign trial = {rem_reg[k-1], low_reg[k-1][QUO_W-1]};
        assign diff  = {1'b0, trial} - {2'b00, den_reg[k-1]};
        assign ge    = ~diff[DET_W+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            ovf_reg[k] <= ovf_reg[k-1];
            neg_reg[k] <= neg_reg[k-1];
            rem_reg[k] <= ge ? diff[DET_W-1:0] : trial[DET_W-1:0];
            den_reg[k] <= den_reg[k-1];
            low_reg[k] <= {low_reg[k-1][QUO_W-2:0], 1'b0};
            quo_reg[k] <= {quo_reg[k-1][QUO_W-2:0], ge};
        end
    end

    always_comb
    begin
        lim      = neg_reg[QUO_W] ? LIM_NEG : LIM_POS;
        clip     = ovf_reg[QUO_W] || (quo_reg[QUO_W] > lim);
        mag_sat  = clip ? lim : quo_reg[QUO_W];
        signed_q = neg_reg[QUO_W] ? (~mag_sat + 1'b1) : mag_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= valid_reg[QUO_W];
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg <= signed_q[DATA_WIDTH-1:0];
        out_sat_reg   <= clip;
    end

    always_comb
    begin
        dout.valid = out_valid_reg;
        dout.value = out_value_reg;
        dout.sat   = out_sat_reg;
    end

    `MI3_ASSERT_IMPL(a_rem_below_den, valid_reg[QUO_W] && !ovf_reg[QUO_W], rem_reg[QUO_W] < den_reg[QUO_W], "divider remainder not below divisor")
    `MI3_ASSERT_NEXT(a_ovf_clips, valid_reg[QUO_W] && ovf_reg[QUO_W], dout.valid && dout.sat, "quotient overflow did not saturate")

endmodule

// File: design/matrix_inverse_3x3.sv
// Top level of the 3x3 fixed-point matrix inverse (adjugate over determinant).
// Depends on mi3_pkg, mi3_minor, mi3_det, mi3_div and the assertion macro header.
//
// Usage: drive one matrix beat on mat with start high; it is accepted at the
// rising edge where start is high and busy is low. busy is always low, so a
// new matrix may be accepted in every cycle. Entries are signed Q16.16.
// One result beat appears on result for exactly one cycle with done high.
// Between accept and done lie two stages for the minors, three for the
// determinant, one setup stage, DATA_WIDTH+3 divider stages and one output
// register. Throughput is one matrix per cycle; the divider is a restoring
// pipeline with one quotient bit per stage, nine copies side by side, and it
// sets the depth. Results come back in order.
// A zero determinant gives all-zero entries with singular set; an entry out
// of range is clamped and sets saturated. Reset clears every valid bit, so
// beats in flight are dropped and no stray done follows. The receiver cannot
// stall the block: each result must be taken in the cycle it is shown.
`include "matrix_inverse_3x3_assert.svh"

module matrix_inverse_3x3
    import mi3_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  matrix_t  mat,
    output logic     done,
    output inverse_t result
);

    minor_bus_t minor_bus;
    det_bus_t   det_bus;

    // Setup stage: magnitudes and signs for the dividers.
    logic                 det_neg;
    det_mag_t             den_next;
    logic                 sing_next;
    logic [N_ENTRY-1:0]   neg_next;
    minor_mag_t           mag_next [N_ENTRY];

    logic                 prep_valid_reg;
    det_mag_t             den_reg;
    logic                 sing_reg;
    logic [N_ENTRY-1:0]   neg_reg;
    minor_mag_t           mag_reg  [N_ENTRY];

    div_out_t             dout [N_ENTRY];
    logic [N_ENTRY-1:0]   sat_vec;
    logic                 sing_line_reg [DIV_LAT];

    inverse_t             result_next;
    inverse_t             result_reg;
    logic                 done_reg;

    // The pipeline never holds off the sender.
    assign busy = 1'b0;

    mi3_minor u_minor (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start && !busy),
        .mat      (mat),
        .out      (minor_bus)
    );

    mi3_det u_det (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (minor_bus),
        .out   (det_bus)
    );

    always_comb
    begin
        det_neg   = det_bus.det[DET_W-1];
        den_next  = det_neg ? det_mag_t'(-det_bus.det) : det_mag_t'(det_bus.det);
        sing_next = (det_bus.det == '0);
    end

    // The numerator sign follows the cofactor: odd output positions negate the
    // minor, and a zero minor counts as non-negative either way.
    for (genvar i = 0; i < N_ENTRY; i++) begin : g_entry
        minor_t mi;
        logic   num_neg;

        assign mi          = det_bus.m[COF_OF_OUT[i]];
        assign num_neg     = (i % 2 == 1) ? (!mi[MINOR_W-1] && (mi != '0)) : mi[MINOR_W-1];
        assign neg_next[i] = num_neg ^ det_neg;
        assign mag_next[i] = mi[MINOR_W-1] ? minor_mag_t'(-mi) : minor_mag_t'(mi);

        mi3_div u_div (
            .clk   (clk),
            .rst_n (rst_n),
            .din   ('{valid: prep_valid_reg, neg: neg_reg[i], mag: mag_reg[i], den: den_reg}),
            .dout  (dout[i])
        );

        assign sat_vec[i] = dout[i].sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
        end
        else
        begin
            prep_valid_reg <= det_bus.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg  <= den_next;
        sing_reg <= sing_next;
        neg_reg  <= neg_next;
        mag_reg  <= mag_next;
    end

    // The singular flag waits alongside the dividers.
    always_ff @(posedge clk)
    begin
        sing_line_reg[0] <= sing_reg;
        for (int k = 1; k < DIV_LAT; k++)
        begin
            sing_line_reg[k] <= sing_line_reg[k-1];
        end
    end

    always_comb
    begin
        result_next = '0;
        if (sing_line_reg[DIV_LAT-1])
        begin
            result_next.singular = 1'b1;
        end
        else
        begin
            result_next.inv_xx    = dout[0].value;
            result_next.inv_xy    = dout[1].value;
            result_next.inv_xz    = dout[2].value;
            result_next.inv_yx    = dout[3].value;
            result_next.inv_yy    = dout[4].value;
            result_next.inv_yz    = dout[5].value;
            result_next.inv_zx    = dout[6].value;
            result_next.inv_zy    = dout[7].value;
            result_next.inv_zz    = dout[8].value;
            result_next.saturated = |sat_vec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dout[0].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    `MI3_ASSERT_IMPL(a_done_has_source, done, $past(start && !busy, LATENCY), "result beat without a matching accepted matrix")
    `MI3_ASSERT_IMPL(a_accept_gives_done, start && !busy, ##LATENCY done, "accepted matrix produced no result beat")
    `MI3_ASSERT_IMPL(a_singular_clean, done && result.singular, !result.saturated && result.inv_xx == '0 && result.inv_yy == '0 && result.inv_zz == '0 && result.inv_xy == '0 && result.inv_zx == '0, "singular result is not all zero")

endmodule

// File: bench/tb_matrix_inverse_3x3.sv
// Self-checking bench for matrix_inverse_3x3: exact cofactor and determinant
// arithmetic predicts each inverse beat. Depends on mi3_pkg and the block's RTL.
module tb_matrix_inverse_3x3;
    import mi3_pkg::*;

    // Wide enough for the determinant of full-range entries and the
    // numerator shifted up by twice the fraction width, with room to spare.
    typedef logic signed [199:0] exact_t;

    // Keeps the expected inverse beats in arrival order and compares each
    // result beat against the oldest one.
    class inverse_scoreboard;
        inverse_t expected_q[$];
        int       mismatches;
        int       checked;
        int       singular_seen;
        int       clamped_seen;

        function exact_t entry_at(entry_t e [3][3], int r, int c);
            return exact_t'(e[r % 3][c % 3]);
        endfunction

        // Signed cofactor of position (r, c) by the cyclic index rule.
        function exact_t cofactor(entry_t e [3][3], int r, int c);
            return entry_at(e, r + 1, c + 1) * entry_at(e, r + 2, c + 2)
                 - entry_at(e, r + 1, c + 2) * entry_at(e, r + 2, c + 1);
        endfunction

        function inverse_t predict_inverse(matrix_t m);
            entry_t   e [3][3];
            entry_t   q_out [9];
            exact_t   det;
            exact_t   num;
            exact_t   quo;
            exact_t   lim;
            logic     neg;
            inverse_t res;
            e = '{'{m.m_xx, m.m_xy, m.m_xz},
                  '{m.m_yx, m.m_yy, m.m_yz},
                  '{m.m_zx, m.m_zy, m.m_zz}};
            det = 0;
            for (int c = 0; c < 3; c++)
                det += exact_t'(e[0][c]) * cofactor(e, 0, c);
            res = '0;
            if (det == 0)
            begin
                res.singular = 1'b1;
                return res;
            end
            for (int i = 0; i < 9; i++)
            begin
                // The inverse is the transposed cofactor matrix over det.
                num = cofactor(e, i % 3, i / 3);
                neg = (num < 0) != (det < 0);
                quo = ((num < 0 ? -num : num) <<< (2 * FRAC_BITS))
                      / (det < 0 ? -det : det);
                lim = (exact_t'(1) <<< (DATA_WIDTH - 1)) - (neg ? 0 : 1);
                if (quo > lim)
                begin
                    quo = lim;
                    res.saturated = 1'b1;
                end
                q_out[i] = entry_t'(neg ? -quo : quo);
            end
            {res.inv_xx, res.inv_xy, res.inv_xz, res.inv_yx, res.inv_yy,
             res.inv_yz, res.inv_zx, res.inv_zy, res.inv_zz} =
                {q_out[0], q_out[1], q_out[2], q_out[3], q_out[4],
                 q_out[5], q_out[6], q_out[7], q_out[8]};
            return res;
        endfunction

        function void note_matrix(matrix_t m);
            expected_q.push_back(predict_inverse(m));
        endfunction

        function void check_inverse(inverse_t got);
            inverse_t want;
            checked++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result beat %p", got);
                return;
            end
            want = expected_q.pop_front();
            if (got.singular)
                singular_seen++;
            if (got.saturated)
                clamped_seen++;
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result beat %0d\n  expected %p\n  actual   %p",
                             checked, want, got);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    matrix_t  mat;
    logic     done;
    inverse_t result;

    inverse_scoreboard sb;
    int                idle_cycles;
    int                accepted;

    localparam int WATCHDOG_LIMIT = 20 * LATENCY + 200;
    localparam entry_t ONE = entry_t'(1) <<< FRAC_BITS;

    matrix_inverse_3x3 dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .mat    (mat),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Both beats are sampled at the rising edge; the block's outputs update
    // only through nonblocking assignments after this process reads them.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                sb.note_matrix(mat);
                accepted++;
            end
            if (done)
                sb.check_inverse(result);
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("ERROR: no beat moved for %0d cycles", idle_cycles);
                $display("FAIL matrix_inverse_3x3");
                $finish;
            end
        end
    end

    // Presents one matrix from the falling edge and holds it until accepted.
    task automatic send_matrix(matrix_t m);
        @(negedge clk);
        start <= 1'b1;
        mat   <= m;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic pause_sender(int cycles);
        @(negedge clk);
        start <= 1'b0;
        mat   <= matrix_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom, $urandom});
        repeat (cycles) @(negedge clk);
    endtask

    function automatic matrix_t diag_matrix(entry_t d);
        matrix_t m;
        m = '0;
        m.m_xx = d;
        m.m_yy = d;
        m.m_zz = d;
        return m;
    endfunction

    function automatic matrix_t fill_matrix(entry_t v);
        return {9{v}};
    endfunction

    // Entries near unity keep most inverses in range; a few raw random
    // words exercise every bit of every field.
    function automatic entry_t pick_entry(int style);
        case (style)
            0: return entry_t'($urandom);
            1: return entry_t'($urandom_range(0, 8 * ONE)) - 4 * ONE;
            default: return entry_t'($urandom_range(0, 64)) - 32;
        endcase
    endfunction

    function automatic matrix_t random_matrix();
        entry_t e [9];
        int     style;
        int     shape;
        style = $urandom_range(0, 3) == 0 ? 0 : ($urandom_range(0, 5) == 0 ? 2 : 1);
        for (int i = 0; i < 9; i++)
            e[i] = pick_entry(style);
        shape = $urandom_range(0, 9);
        if (shape == 0)
        begin
            // Two equal rows give an exactly zero determinant.
            e[6] = e[0];
            e[7] = e[1];
            e[8] = e[2];
        end
        else if (shape == 1)
        begin
            // A zero column is singular too.
            e[1] = 0;
            e[4] = 0;
            e[7] = 0;
        end
        else if (shape == 2)
        begin
            // Dominant diagonal with tiny off-diagonal terms.
            for (int i = 0; i < 9; i++)
                if (i % 4 != 0)
                    e[i] = pick_entry(2);
        end
        return {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
    endfunction

    initial
    begin
        matrix_t directed [$];
        int      burst;

        sb          = new();
        idle_cycles = 0;
        accepted    = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        mat         = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed beats: identity, scaled and signed diagonals, the zero
        // matrix, full-scale fills, a tiny diagonal that clamps high, and a
        // diagonal whose inverse lands exactly on the most negative value.
        directed.push_back(diag_matrix(ONE));
        directed.push_back(diag_matrix(-ONE));
        directed.push_back(diag_matrix(2 * ONE));
        directed.push_back(diag_matrix(ONE / 2));
        directed.push_back('0);
        directed.push_back(fill_matrix(32'sh7fff_ffff));
        directed.push_back(fill_matrix(32'sh8000_0000));
        directed.push_back(fill_matrix(-1));
        directed.push_back(diag_matrix(1));
        directed.push_back(diag_matrix(-1));
        directed.push_back(diag_matrix(2));
        directed.push_back(diag_matrix(-2));
        directed.push_back(diag_matrix(32'sh7fff_ffff));
        directed.push_back(diag_matrix(32'sh8000_0000));
        directed.push_back({32'sh7fff_ffff, 32'sh8000_0000, 32'sh0000_0001,
                            32'sh8000_0000, 32'sh7fff_ffff, 32'shffff_ffff,
                            32'sh0000_0001, 32'shffff_ffff, 32'sh7fff_ffff});
        directed.push_back({ONE, 2 * ONE, 3 * ONE, entry_t'(0), ONE, 4 * ONE,
                            5 * ONE, 6 * ONE, entry_t'(0)});
        directed.push_back({ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE,
                            6 * ONE, 7 * ONE, 8 * ONE, 9 * ONE});
        directed.push_back({32'sh5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555,
                            32'shaaaa_aaaa, 32'sh5555_5555, 32'shaaaa_aaab,
                            32'sh1234_5678, 32'shedcb_a987, 32'sh0f0f_0f0f});
        foreach (directed[i])
            send_matrix(directed[i]);

        // Hold off until the pipeline has drained completely once.
        pause_sender(1);
        while (sb.pending() != 0)
            @(negedge clk);

        // Random bursts, with some back-to-back stretches and some gaps.
        while (accepted < 430)
        begin
            burst = $urandom_range(1, 40);
            for (int i = 0; i < burst; i++)
                send_matrix(random_matrix());
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 2 * LATENCY));
        end
        pause_sender(0);

        while (sb.pending() != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);

        $display("Run covered %0d matrices: %0d singular, %0d with clamped entries.",
                 accepted, sb.singular_seen, sb.clamped_seen);
        if (sb.mismatches == 0)
            $display("PASS matrix_inverse_3x3");
        else
        begin
            $display("%0d mismatching result beats", sb.mismatches);
            $display("FAIL matrix_inverse_3x3");
        end
        $finish;
    end
endmodule
